FILE: rtl/clc_pkg.sv
// Shared types and codes for the charge-limited LRU cache.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package clc_pkg;

    localparam int KEY_W    = 64;
    localparam int HASH_W   = 32;
    localparam int VAL_W    = 32;
    localparam int CHARGE_W = 16;
    localparam int USAGE_W  = 20;

    localparam logic [USAGE_W-1:0] CAP_RESET = 20'd65535;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_LOOKUP   = 3'd0,
        KIND_DONE     = 3'd1,
        KIND_ERASED   = 3'd2,
        KIND_EVICTED  = 3'd3,
        KIND_REPLACED = 3'd4
    } kind_t;

    // One result record as it waits in the result queue.
    typedef struct packed {
        logic [2:0]          kind;
        logic                hit;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic [CHARGE_W-1:0] charge;
    } rec_t;

endpackage

FILE: rtl/clc_if.sv
// Request and response channel interfaces of the cache.
// Depends on clc_pkg for the field widths.
`timescale 1ns / 1ps
interface clc_req_if;
    import clc_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [KEY_W-1:0]    key;
    logic [HASH_W-1:0]   key_hash;
    logic [VAL_W-1:0]    in_value;
    logic [CHARGE_W-1:0] in_charge;

    modport source (output valid, op, key, key_hash, in_value, in_charge, input ready);
    modport sink   (input valid, op, key, key_hash, in_value, in_charge, output ready);
endinterface

interface clc_rsp_if;
    import clc_pkg::*;
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic                hit;
    logic [KEY_W-1:0]    out_key;
    logic [VAL_W-1:0]    out_value;
    logic [CHARGE_W-1:0] out_charge;
    logic [USAGE_W-1:0]  usage_now;
    logic                last;

    modport source (output valid, kind, hit, out_key, out_value, out_charge, usage_now, last,
                    input ready);
    modport sink   (input valid, kind, hit, out_key, out_value, out_charge, usage_now, last,
                    output ready);
endinterface

FILE: rtl/clc_entry_store.sv
// Value and charge memory of the cache entries, one write and one read port.
// Depends on clc_pkg; read data is registered.
`timescale 1ns / 1ps
module clc_entry_store
    import clc_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(ENTRIES)-1:0] waddr,
    input  logic [VALUE_BITS-1:0]      wvalue,
    input  logic [CHARGE_W-1:0]        wcharge,
    input  logic [$clog2(ENTRIES)-1:0] raddr,
    output logic [VALUE_BITS-1:0]      rvalue,
    output logic [CHARGE_W-1:0]        rcharge
);

    logic [VALUE_BITS+CHARGE_W-1:0] mem [ENTRIES];
    logic [VALUE_BITS+CHARGE_W-1:0] rdata_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wvalue, wcharge};
        end
        rdata_reg <= mem[raddr];
    end

    assign rvalue  = rdata_reg[VALUE_BITS+CHARGE_W-1:CHARGE_W];
    assign rcharge = rdata_reg[CHARGE_W-1:0];

endmodule

FILE: rtl/clc_result_queue.sv
// Memory that holds the result records of one operation until it completes.
// Depends on clc_pkg for the record type; read data is registered.
`timescale 1ns / 1ps
module clc_result_queue
    import clc_pkg::*;
#(
    parameter int DEPTH = 18
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  rec_t                     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output rec_t                     rdata
);

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/charge_limited_lru_cache.sv
// Charge-limited LRU cache: lookup, insert and erase on a table of ENTRIES entries.
// Lookup and erase go from the match state to a single result; insert adds duplicate and fit
// checks and an eviction step per evicted entry; each result beat is read, then offered.
// Throughput: one request at a time; the next request is taken after the last beat leaves.
// Each eviction reads the least-recent entry from the entry store, then removes it next cycle.
// Reset (rst_n, async low) clears valid bits, ranks, usage and sets capacity to 65535.
`timescale 1ns / 1ps
module charge_limited_lru_cache
    import clc_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [USAGE_W-1:0] cfg_data,
    clc_req_if.sink            req,
    clc_rsp_if.source          rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int QD = ENTRIES + 2;
    localparam int QW = $clog2(QD);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MATCH,
        S_LOOK,
        S_ERASE,
        S_DUP,
        S_INS_CHK,
        S_INS_REJ,
        S_INS_FIT,
        S_EVICT,
        S_INS_WRITE,
        S_DRAIN_RD,
        S_DRAIN_OUT
    } state_t;

    state_t               state_reg;
    logic [USAGE_W-1:0]   cap_reg;
    logic [USAGE_W-1:0]   usage_reg;
    logic [CW-1:0]        count_reg;
    logic [ENTRIES-1:0]   valid_reg;
    logic [IW-1:0]        rank_reg [ENTRIES];
    logic [KEY_W-1:0]     tag_key_reg [ENTRIES];
    logic [HASH_W-1:0]    tag_hash_reg [ENTRIES];

    logic [1:0]           op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [HASH_W-1:0]    hash_reg;
    logic [VAL_W-1:0]     value_reg;
    logic [CHARGE_W-1:0]  charge_reg;
    logic                 hit_reg;
    logic [IW-1:0]        victim_reg;
    logic [QW-1:0]        wptr_reg;
    logic [QW-1:0]        rptr_reg;

    logic                 match_found;
    logic [IW-1:0]        match_idx;
    logic                 oldest_found;
    logic [IW-1:0]        oldest_idx;
    logic [IW-1:0]        free_idx;
    logic [IW-1:0]        store_raddr;
    logic [VALUE_BITS-1:0] store_rvalue;
    logic [CHARGE_W-1:0]  store_rcharge;
    logic [VALUE_BITS-1:0] in_vstore;
    logic [63:0]          in_vfull;
    logic [63:0]          in_vback;
    logic [63:0]          rd_vback;
    logic [VAL_W-1:0]     in_val32;
    logic [VAL_W-1:0]     rd_val32;
    logic [IW-1:0]        victim_rank;
    logic [USAGE_W-1:0]   usage_sub;
    logic [USAGE_W:0]     usage_want;
    logic                 over_cap;
    logic                 table_full;
    logic                 oversized;
    logic                 push;
    rec_t                 push_rec;
    rec_t                 q_rdata;

    // Value kept to VALUE_BITS low bits, both on the way in and on the way out.
    assign in_vfull  = 64'(value_reg);
    assign in_vstore = in_vfull[VALUE_BITS-1:0];
    assign in_vback  = 64'(in_vstore);
    assign in_val32  = in_vback[VAL_W-1:0];
    assign rd_vback  = 64'(store_rvalue);
    assign rd_val32  = rd_vback[VAL_W-1:0];

    // Parallel tag compare, least-recent search and free slot search.
    always_comb
    begin
        match_found  = 1'b0;
        match_idx    = '0;
        oldest_found = 1'b0;
        oldest_idx   = '0;
        free_idx     = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && tag_key_reg[i] == key_reg && tag_hash_reg[i] == hash_reg)
            begin
                match_found = 1'b1;
                match_idx   = IW'(i);
            end
            if (valid_reg[i] && CW'(rank_reg[i]) == count_reg - CW'(1))
            begin
                oldest_found = 1'b1;
                oldest_idx   = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    // Usage arithmetic and insert checks.
    assign victim_rank = rank_reg[victim_reg];
    assign usage_sub   = (usage_reg >= USAGE_W'(store_rcharge))
                         ? usage_reg - USAGE_W'(store_rcharge) : '0;
    assign usage_want  = {1'b0, usage_reg} + (USAGE_W+1)'(charge_reg);
    assign over_cap    = usage_want > {1'b0, cap_reg};
    assign table_full  = count_reg == CW'(ENTRIES);
    assign oversized   = USAGE_W'(charge_reg) > cap_reg;

    // Entry store read address follows the entry the next state works on.
    always_comb
    begin
        unique case (state_reg)
            S_MATCH:   store_raddr = match_idx;
            S_INS_FIT: store_raddr = oldest_idx;
            default:   store_raddr = victim_reg;
        endcase
    end

    // Result record pushed in the reporting states (S_INS_CHK only for an oversized charge).
    always_comb
    begin
        push     = 1'b0;
        push_rec = '{kind: KIND_LOOKUP, hit: 1'b0, key: key_reg, value: '0, charge: '0};
        unique case (state_reg)
            S_LOOK, S_ERASE:
            begin
                push          = 1'b1;
                push_rec.kind = (state_reg == S_LOOK) ? KIND_LOOKUP : KIND_ERASED;
                push_rec.hit  = hit_reg;
                if (hit_reg)
                begin
                    push_rec.key    = tag_key_reg[victim_reg];
                    push_rec.value  = rd_val32;
                    push_rec.charge = store_rcharge;
                end
            end
            S_DUP, S_EVICT:
            begin
                push     = 1'b1;
                push_rec = '{kind: (state_reg == S_DUP) ? KIND_REPLACED : KIND_EVICTED,
                             hit: 1'b1, key: tag_key_reg[victim_reg],
                             value: rd_val32, charge: store_rcharge};
            end
            S_INS_CHK:
            begin
                push     = oversized;
                push_rec = '{kind: KIND_EVICTED, hit: 1'b0, key: key_reg,
                             value: in_val32, charge: charge_reg};
            end
            S_INS_REJ, S_INS_WRITE:
            begin
                push     = 1'b1;
                push_rec = '{kind: KIND_DONE, hit: (state_reg == S_INS_WRITE),
                             key: key_reg, value: in_val32, charge: charge_reg};
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    clc_entry_store #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .clk     (clk),
        .we      (state_reg == S_INS_WRITE),
        .waddr   (free_idx),
        .wvalue  (in_vstore),
        .wcharge (charge_reg),
        .raddr   (store_raddr),
        .rvalue  (store_rvalue),
        .rcharge (store_rcharge)
    );

    clc_result_queue #(
        .DEPTH (QD)
    ) u_queue (
        .clk   (clk),
        .we    (push),
        .waddr (wptr_reg),
        .wdata (push_rec),
        .raddr (rptr_reg),
        .rdata (q_rdata)
    );

    // Handshake and response payload.
    assign req.ready      = state_reg == S_IDLE;
    assign rsp.valid      = state_reg == S_DRAIN_OUT;
    assign rsp.kind       = q_rdata.kind;
    assign rsp.hit        = q_rdata.hit;
    assign rsp.out_key    = q_rdata.key;
    assign rsp.out_value  = q_rdata.value;
    assign rsp.out_charge = q_rdata.charge;
    assign rsp.usage_now  = usage_reg;
    assign rsp.last       = rptr_reg == wptr_reg - QW'(1);

    // Request capture and tag writes, without reset.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg     <= req.op;
            key_reg    <= req.key;
            hash_reg   <= req.key_hash;
            value_reg  <= req.in_value;
            charge_reg <= req.in_charge;
        end
        if (state_reg == S_INS_WRITE)
        begin
            tag_key_reg[free_idx]  <= key_reg;
            tag_hash_reg[free_idx] <= hash_reg;
        end
    end

    // Sequencer with valid bits, recency ranks and usage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cap_reg    <= CAP_RESET;
            usage_reg  <= '0;
            count_reg  <= '0;
            valid_reg  <= '0;
            hit_reg    <= 1'b0;
            victim_reg <= '0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (push)
            begin
                wptr_reg <= wptr_reg + QW'(1);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    wptr_reg <= '0;
                    rptr_reg <= '0;
                    if (req.valid && op_t'(req.op) != OP_NONE)
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    hit_reg    <= match_found;
                    victim_reg <= match_idx;
                    unique case (op_t'(op_reg))
                        OP_LOOKUP: state_reg <= S_LOOK;
                        OP_ERASE:  state_reg <= S_ERASE;
                        default:   state_reg <= match_found ? S_DUP : S_INS_CHK;
                    endcase
                end
                S_LOOK:
                begin
                    // Make the found entry most recent.
                    if (hit_reg)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (valid_reg[i] && rank_reg[i] < victim_rank)
                            begin
                                rank_reg[i] <= rank_reg[i] + IW'(1);
                            end
                        end
                        rank_reg[victim_reg] <= '0;
                    end
                    state_reg <= S_DRAIN_RD;
                end
                S_ERASE, S_DUP, S_EVICT:
                begin
                    // Remove the victim and close the gap in the ranks.
                    if (hit_reg || state_reg != S_ERASE)
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (valid_reg[i] && rank_reg[i] > victim_rank)
                            begin
                                rank_reg[i] <= rank_reg[i] - IW'(1);
                            end
                        end
                        rank_reg[victim_reg]  <= '0;
                        valid_reg[victim_reg] <= 1'b0;
                        count_reg             <= count_reg - CW'(1);
                        usage_reg             <= usage_sub;
                    end
                    unique case (state_reg)
                        S_ERASE: state_reg <= S_DRAIN_RD;
                        S_DUP:   state_reg <= S_INS_CHK;
                        default: state_reg <= S_INS_FIT;
                    endcase
                end
                S_INS_CHK:
                begin
                    state_reg <= oversized ? S_INS_REJ : S_INS_FIT;
                end
                S_INS_REJ:
                begin
                    state_reg <= S_DRAIN_RD;
                end
                S_INS_FIT:
                begin
                    // Evict least-recent entries until a slot is free and the charge fits.
                    if (table_full || over_cap)
                    begin
                        if (oldest_found)
                        begin
                            victim_reg <= oldest_idx;
                            state_reg  <= S_EVICT;
                        end
                        else
                        begin
                            usage_reg <= '0;
                            state_reg <= S_INS_WRITE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_INS_WRITE;
                    end
                end
                S_INS_WRITE:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            rank_reg[i] <= rank_reg[i] + IW'(1);
                        end
                    end
                    rank_reg[free_idx]  <= '0;
                    valid_reg[free_idx] <= 1'b1;
                    count_reg           <= count_reg + CW'(1);
                    usage_reg           <= usage_want[USAGE_W-1:0];
                    state_reg           <= S_DRAIN_RD;
                end
                S_DRAIN_RD:
                begin
                    state_reg <= S_DRAIN_OUT;
                end
                S_DRAIN_OUT:
                begin
                    // One beat per queued record; the final beat returns to idle.
                    if (rsp.ready)
                    begin
                        rptr_reg  <= rptr_reg + QW'(1);
                        state_reg <= rsp.last ? S_IDLE : S_DRAIN_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/clc_checker.sv
// Port-level checks of the cache and the bind that attaches them to the top level.
// Depends on clc_pkg and on the ports of charge_limited_lru_cache.
`timescale 1ns / 1ps
module clc_checker
    import clc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         kind,
    input logic [KEY_W-1:0]   out_key,
    input logic [USAGE_W-1:0] usage_now,
    input logic               last
);

    // A stalled response beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(kind))
        else $error("stalled response beat changed");

    // The block never takes a request while results are still being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request accepted during response delivery");

    // All beats of one request report the same usage.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> $stable(usage_now))
        else $error("usage changed between beats of one request");

    // Result kinds stay within the defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= KIND_REPLACED)
        else $error("undefined result kind");

    // After the final beat is taken the block is ready for the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> in_ready && !out_valid)
        else $error("block not idle after final beat");

endmodule

bind charge_limited_lru_cache clc_checker u_clc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .kind      (rsp.kind),
    .out_key   (rsp.out_key),
    .usage_now (rsp.usage_now),
    .last      (rsp.last)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the charge-limited LRU cache.
// Depends on clc_pkg and the clc_req_if / clc_rsp_if interfaces of the block.
// A directed table, then random phases at several capacities, checked beat by beat.
`timescale 1ns / 1ps
module tb_top;
    import clc_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SIZE   = 12;

    // One expected response beat.
    typedef struct {
        kind_t               kind;
        logic                hit;
        logic [KEY_W-1:0]    key;
        logic [VAL_W-1:0]    value;
        logic [CHARGE_W-1:0] charge;
        logic [USAGE_W-1:0]  usage;
        logic                last;
    } beat_t;

    // One row of the directed table; chk marks a first beat that is typed in.
    typedef struct {
        op_t                 op;
        logic [KEY_W-1:0]    key;
        logic [HASH_W-1:0]   hash;
        logic [VAL_W-1:0]    value;
        logic [CHARGE_W-1:0] charge;
        bit                  chk;
        kind_t               first_kind;
        bit                  first_hit;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [USAGE_W-1:0] cfg_data;

    clc_req_if req_ch ();
    clc_rsp_if rsp_ch ();

    charge_limited_lru_cache dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // Shadow copy of the cache table.
    bit                  shadow_valid [NUM_ENTRIES];
    logic [KEY_W-1:0]    shadow_key   [NUM_ENTRIES];
    logic [HASH_W-1:0]   shadow_hash  [NUM_ENTRIES];
    logic [VAL_W-1:0]    shadow_value [NUM_ENTRIES];
    logic [CHARGE_W-1:0] shadow_charge[NUM_ENTRIES];
    int unsigned         shadow_rank  [NUM_ENTRIES];
    int unsigned         shadow_usage;
    int unsigned         shadow_cap;

    beat_t pending_beats[$];
    int    errors;
    int    cycles;
    bit    calm;
    bit    hold_request;
    int    hold_left;
    int    rsp_stall;

    logic [KEY_W-1:0]  pool_key [POOL_SIZE];
    logic [HASH_W-1:0] pool_hash[POOL_SIZE];

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int find_match(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (shadow_valid[i] && shadow_key[i] == k && shadow_hash[i] == h)
                return i;
        return -1;
    endfunction

    function automatic int find_oldest();
        int best;
        best = -1;
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (shadow_valid[i] && (best < 0 || shadow_rank[i] > shadow_rank[best]))
                best = i;
        return best;
    endfunction

    function automatic void drop_entry(int e);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (shadow_valid[i] && shadow_rank[i] > shadow_rank[e])
                shadow_rank[i]--;
        shadow_valid[e] = 0;
        shadow_rank[e]  = 0;
        shadow_usage = (shadow_usage >= shadow_charge[e]) ? shadow_usage - shadow_charge[e] : 0;
    endfunction

    function automatic beat_t make_beat(kind_t kd, logic h, logic [KEY_W-1:0] k,
                                        logic [VAL_W-1:0] v, logic [CHARGE_W-1:0] c);
        beat_t b;
        b.kind = kd; b.hit = h; b.key = k; b.value = v; b.charge = c;
        b.usage = '0; b.last = 0;
        return b;
    endfunction

    function automatic beat_t entry_beat(kind_t kd, int e);
        return make_beat(kd, 1'b1, shadow_key[e], shadow_value[e], shadow_charge[e]);
    endfunction

    // Apply one accepted request to the shadow table and queue the beats it causes.
    function automatic void predict_request(op_t op, logic [KEY_W-1:0] k,
                                            logic [HASH_W-1:0] h, logic [VAL_W-1:0] v,
                                            logic [CHARGE_W-1:0] c);
        beat_t out[$];
        int    e;
        int    slot;
        int    victim;
        if (op == OP_NONE)
            return;
        e = find_match(k, h);
        case (op)
            OP_LOOKUP:
            begin
                if (e >= 0)
                begin
                    out = {out, entry_beat(KIND_LOOKUP, e)};
                    // Make the hit most recent.
                    for (int i = 0; i < NUM_ENTRIES; i++)
                        if (shadow_valid[i] && shadow_rank[i] < shadow_rank[e])
                            shadow_rank[i]++;
                    shadow_rank[e] = 0;
                end
                else
                    out = {out, make_beat(KIND_LOOKUP, 1'b0, k, '0, '0)};
            end
            OP_ERASE:
            begin
                if (e >= 0)
                begin
                    out = {out, entry_beat(KIND_ERASED, e)};
                    drop_entry(e);
                end
                else
                    out = {out, make_beat(KIND_ERASED, 1'b0, k, '0, '0)};
            end
            default:
            begin
                if (e >= 0)
                begin
                    out = {out, entry_beat(KIND_REPLACED, e)};
                    drop_entry(e);
                end
                if (c > shadow_cap)
                begin
                    out = {out, make_beat(KIND_EVICTED, 1'b0, k, v, c)};
                    out = {out, make_beat(KIND_DONE, 1'b0, k, v, c)};
                end
                else
                begin
                    slot = -1;
                    for (int i = NUM_ENTRIES - 1; i >= 0; i--)
                        if (!shadow_valid[i])
                            slot = i;
                    if (slot < 0)
                    begin
                        slot = find_oldest();
                        if (slot < 0)
                            slot = 0;
                        else
                        begin
                            out = {out, entry_beat(KIND_EVICTED, slot)};
                            drop_entry(slot);
                        end
                    end
                    // Evict until the new charge fits.
                    while (shadow_usage + c > shadow_cap)
                    begin
                        victim = find_oldest();
                        if (victim < 0)
                        begin
                            shadow_usage = 0;
                            break;
                        end
                        out = {out, entry_beat(KIND_EVICTED, victim)};
                        drop_entry(victim);
                    end
                    for (int i = 0; i < NUM_ENTRIES; i++)
                        if (shadow_valid[i])
                            shadow_rank[i]++;
                    shadow_valid[slot]  = 1;
                    shadow_key[slot]    = k;
                    shadow_hash[slot]   = h;
                    shadow_value[slot]  = v;
                    shadow_charge[slot] = c;
                    shadow_rank[slot]   = 0;
                    shadow_usage = (shadow_usage + c) & 32'hFFFFF;
                    out = {out, make_beat(KIND_DONE, 1'b1, k, v, c)};
                end
            end
        endcase
        foreach (out[i])
        begin
            out[i].usage = shadow_usage[USAGE_W-1:0];
            out[i].last  = (i == out.size() - 1);
            pending_beats = {pending_beats, out[i]};
        end
    endfunction

    // Offer one request beat and hold it until accepted; returns the index of its first beat.
    task automatic send_request(op_t op, logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                                logic [VAL_W-1:0] v, logic [CHARGE_W-1:0] c,
                                output int first_idx);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.key       <= k;
        req_ch.key_hash  <= h;
        req_ch.in_value  <= v;
        req_ch.in_charge <= c;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        first_idx = pending_beats.size();
        predict_request(op, k, h, v, c);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = pick_gap();
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write the capacity only while the block is idle.
    task automatic write_capacity(logic [USAGE_W-1:0] cap);
        req_ch.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_cap = 32'(cap);
    endtask

    task automatic send_random(int count, int charge_max, bit hold_once, bit pause_often);
        op_t                 op;
        logic [KEY_W-1:0]    k;
        logic [HASH_W-1:0]   h;
        logic [CHARGE_W-1:0] c;
        int                  r;
        int                  p;
        int                  idx;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 45) ? OP_INSERT : (r < 70) ? OP_LOOKUP : (r < 95) ? OP_ERASE : OP_NONE;
            p = $urandom_range(0, POOL_SIZE - 1);
            k = pool_key[p];
            h = pool_hash[p];
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                k = {$urandom, $urandom};
                h = $urandom;
            end
            else if (r < 13)
                h = $urandom;
            r = $urandom_range(0, 99);
            c = (r < 80) ? CHARGE_W'($urandom_range(0, charge_max))
                : (r < 90) ? 16'd0 : CHARGE_W'($urandom);
            if (hold_once && n == 10)
                hold_request = 1;
            if (pause_often && n % 20 == 19 && pending_beats.size() != 0)
            begin
                req_ch.valid <= 1'b0;
                while (pending_beats.size() != 0)
                    @(posedge clk);
            end
            send_request(op, k, h, $urandom, c, idx);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Response side: random back-pressure and the beat checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_stall    = 0;
            hold_left    = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_beats.size() == 0)
                    report("unexpected beat, key", rsp_ch.out_key, '0);
                else
                begin
                    beat_t b;
                    b = pending_beats[0];
                    pending_beats.delete(0);
                    if (rsp_ch.kind !== b.kind)       report("kind", rsp_ch.kind, b.kind);
                    if (rsp_ch.hit !== b.hit)         report("hit", rsp_ch.hit, b.hit);
                    if (rsp_ch.out_key !== b.key)     report("out_key", rsp_ch.out_key, b.key);
                    if (rsp_ch.out_value !== b.value)
                        report("out_value", rsp_ch.out_value, b.value);
                    if (rsp_ch.out_charge !== b.charge)
                        report("out_charge", rsp_ch.out_charge, b.charge);
                    if (rsp_ch.usage_now !== b.usage)
                        report("usage_now", rsp_ch.usage_now, b.usage);
                    if (rsp_ch.last !== b.last)       report("last", rsp_ch.last, b.last);
                end
            end
            if (hold_request)
            begin
                hold_request = 0;
                hold_left    = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_stall > 0)
            begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    rsp_stall = pick_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        row_t rows[$];
        int   idx;
        logic [KEY_W-1:0] k1;

        errors       = 0;
        cycles       = 0;
        calm         = 1;
        hold_request = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        req_ch.valid     = 1'b0;
        req_ch.op        = OP_LOOKUP;
        req_ch.key       = '0;
        req_ch.key_hash  = '0;
        req_ch.in_value  = '0;
        req_ch.in_charge = '0;
        foreach (shadow_valid[i])
        begin
            shadow_valid[i] = 0;
            shadow_rank[i]  = 0;
        end
        shadow_usage = 0;
        shadow_cap   = 32'(CAP_RESET);
        foreach (pool_key[i])
        begin
            pool_key[i]  = {$urandom, $urandom};
            pool_hash[i] = $urandom;
        end
        k1 = 64'h0123_4567_89AB_CDEF;

        rows = '{
            '{OP_LOOKUP, 64'd0, 32'd0, 32'd0, 16'd0, 1, KIND_LOOKUP, 0},
            '{OP_ERASE, '1, '1, 32'd0, 16'd0, 1, KIND_ERASED, 0},
            '{OP_INSERT, k1, 32'h5A5A_0001, 32'hDEAD_BEEF, 16'd100, 1, KIND_DONE, 1},
            '{OP_LOOKUP, k1, 32'h5A5A_0001, 32'd0, 16'd0, 1, KIND_LOOKUP, 1},
            '{OP_LOOKUP, k1, 32'h5A5A_0002, 32'd0, 16'd0, 1, KIND_LOOKUP, 0},
            '{OP_INSERT, k1, 32'h5A5A_0001, 32'h1234_5678, 16'd200, 1, KIND_REPLACED, 1},
            '{OP_INSERT, '1, '1, '1, 16'hFFFF, 1, KIND_EVICTED, 1},
            '{OP_INSERT, 64'd0, 32'd0, 32'd0, 16'd0, 1, KIND_DONE, 1},
            '{OP_NONE, k1, 32'h5A5A_0001, 32'd0, 16'd0, 0, KIND_LOOKUP, 0},
            '{OP_ERASE, '1, '1, 32'd0, 16'd0, 1, KIND_ERASED, 1},
            '{OP_LOOKUP, 64'd0, 32'd0, 32'd0, 16'd0, 1, KIND_LOOKUP, 1}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset capacity.
        foreach (rows[i])
        begin
            send_request(rows[i].op, rows[i].key, rows[i].hash, rows[i].value,
                         rows[i].charge, idx);
            if (rows[i].chk)
            begin
                if (pending_beats[idx].kind !== rows[i].first_kind)
                    report("table kind", pending_beats[idx].kind, rows[i].first_kind);
                if (pending_beats[idx].hit !== rows[i].first_hit)
                    report("table hit", pending_beats[idx].hit, rows[i].first_hit);
            end
        end
        // Fill past the table size so the least-recent entry is pushed out.
        for (int i = 0; i < NUM_ENTRIES + 1; i++)
            send_request(OP_INSERT, {32'hF111_0000, i[31:0]}, i, $urandom, 16'd1, idx);

        // Zero capacity: any nonzero charge is oversized, a zero charge clears the table.
        write_capacity('0);
        send_request(OP_INSERT, k1, 32'h1, 32'h7, 16'd5, idx);
        if (pending_beats[idx].kind !== KIND_EVICTED || pending_beats[idx].hit !== 1'b0)
            report("oversized kind/hit", {pending_beats[idx].kind, pending_beats[idx].hit},
                   {KIND_EVICTED, 1'b0});
        send_request(OP_INSERT, k1, 32'h1, 32'h7, 16'd0, idx);

        // Largest capacity, first without idling, then with it.
        write_capacity('1);
        send_random(30, 65535, 0, 0);
        calm = 0;
        send_random(30, 65535, 0, 0);

        // Small capacity: frequent evictions, one long receiver hold.
        write_capacity(20'd300);
        send_random(60, 120, 1, 0);

        // Mid capacity with pauses until the block drains.
        write_capacity(20'd2000);
        send_random(60, 400, 0, 1);

        req_ch.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: charge_limited_lru_cache.f
rtl/clc_pkg.sv
rtl/clc_if.sv
rtl/clc_entry_store.sv
rtl/clc_result_queue.sv
rtl/charge_limited_lru_cache.sv
rtl/clc_checker.sv
tb/sv/tb_top.sv
